// ----- hw/rtl/eftd_pkg.sv -----
// Package for the earliest free thread dispatcher.
// Holds the fixed field widths and parameter defaults; depends on nothing.
package eftd_pkg;

   localparam int DEF_MAX_THREADS = 16;
   localparam int DEF_TIME_BITS   = 48;

   localparam int DURATION_W = 32;
   localparam int INDEX_W    = 4;
   localparam int START_W    = 48;
   localparam int COUNT_W    = 5;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

endpackage

// ----- hw/rtl/eftd_cell.sv -----
// One thread cell of the dispatcher chain: holds one thread's free time.
// It compares that time against the running minimum handed in by its left
// neighbor and hands the updated minimum to its right neighbor. No package.
module eftd_cell #(
   parameter int TIME_BITS = 48,
   parameter int IDX_W     = 4,
   parameter int CNT_W     = 5,
   parameter int INDEX     = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [CNT_W-1:0]     thread_limit,
   input  logic                 wr_valid,
   input  logic [IDX_W-1:0]     wr_idx,
   input  logic [TIME_BITS-1:0] wr_time,
   input  logic                 in_valid,
   input  logic                 in_found,
   input  logic [TIME_BITS-1:0] in_time,
   input  logic [IDX_W-1:0]     in_idx,
   output logic                 out_valid,
   output logic                 out_found,
   output logic [TIME_BITS-1:0] out_time,
   output logic [IDX_W-1:0]     out_idx
);

   logic [TIME_BITS-1:0] free_time_ff;
   logic                 valid_ff;
   logic                 found_ff;
   logic [TIME_BITS-1:0] time_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic                 active;
   logic                 take_in;

   assign active  = CNT_W'(INDEX) < thread_limit;
   assign take_in = active && (!in_found || (free_time_ff < in_time));

   always_ff @(posedge clock) begin
      if (reset) begin
         free_time_ff <= '0;
         valid_ff     <= 1'b0;
      end else begin
         valid_ff <= in_valid;
         if (wr_valid && (wr_idx == IDX_W'(INDEX))) begin
            free_time_ff <= wr_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         found_ff <= 1'b1;
         time_ff  <= free_time_ff;
         idx_ff   <= IDX_W'(INDEX);
      end else begin
         found_ff <= in_found;
         time_ff  <= in_time;
         idx_ff   <= in_idx;
      end
   end

   assign out_valid = valid_ff;
   assign out_found = found_ff;
   assign out_time  = time_ff;
   assign out_idx   = idx_ff;

endmodule

// ----- hw/rtl/earliest_free_thread_dispatcher.sv -----
// Top level of the earliest free thread dispatcher: the chain of thread
// cells, the saturating update of the winning thread and the ports.
// Depends on eftd_pkg and eftd_cell.

// Each job is a transaction on start/busy. A scan token walks down a row of
// MAX_THREADS cells, one cell per cycle, and collects the earliest free
// active thread (lowest index on ties). The result appears on strobe for one
// cycle, and busy drops in that same cycle; the winner's new free time is
// then written through a register, in time for the next job. A new job is
// taken only once busy is low, so only one job is in the row at a time. The
// receiver cannot stall; the strobe is not repeated. Write thread_count only
// while busy is low.
module earliest_free_thread_dispatcher #(
   parameter int MAX_THREADS = eftd_pkg::DEF_MAX_THREADS,
   parameter int TIME_BITS   = eftd_pkg::DEF_TIME_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [eftd_pkg::DURATION_W-1:0] req_job_duration,
   output logic                            strobe,
   output logic [eftd_pkg::INDEX_W-1:0]    rsp_thread_index,
   output logic [eftd_pkg::START_W-1:0]    rsp_start_time,
   input  logic                            csr_write_enable,
   input  logic [eftd_pkg::COUNT_W-1:0]    csr_write_data
);

   import eftd_pkg::*;

   localparam int IDX_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int CNT_W = $clog2(MAX_THREADS + 1);

   logic [COUNT_W-1:0]    csr_count_ff;
   logic [CNT_W-1:0]      thread_limit;
   logic                  busy_ff;
   logic                  launch_ff;
   logic [DURATION_W-1:0] dur_ff;
   logic                  strobe_ff;
   logic [INDEX_W-1:0]    rsp_index_ff;
   logic [START_W-1:0]    rsp_start_ff;
   logic                  wr_valid_ff;
   logic [IDX_W-1:0]      wr_idx_ff;
   logic [TIME_BITS-1:0]  wr_time_ff;
   logic [TIME_BITS:0]    sum_in;
   logic [TIME_BITS-1:0]  next_time_in;
   logic                  accept;
   logic                  done;

   logic [MAX_THREADS:0]  hop_valid;
   logic [MAX_THREADS:0]  hop_found;
   logic [TIME_BITS-1:0]  hop_time [MAX_THREADS+1];
   logic [IDX_W-1:0]      hop_idx  [MAX_THREADS+1];

   always_comb begin
      if (csr_count_ff == '0) begin
         thread_limit = CNT_W'(1);
      end else if (int'(csr_count_ff) > MAX_THREADS) begin
         thread_limit = CNT_W'(MAX_THREADS);
      end else begin
         thread_limit = CNT_W'(csr_count_ff);
      end
   end

   assign accept = start && !busy_ff;
   assign done   = hop_valid[MAX_THREADS];

   assign hop_valid[0] = launch_ff;
   assign hop_found[0] = 1'b0;
   assign hop_time[0]  = '0;
   assign hop_idx[0]   = '0;

   for (genvar k = 0; k < MAX_THREADS; k++) begin : g_cell
      eftd_cell #(
         .TIME_BITS (TIME_BITS),
         .IDX_W     (IDX_W),
         .CNT_W     (CNT_W),
         .INDEX     (k)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .thread_limit (thread_limit),
         .wr_valid     (wr_valid_ff),
         .wr_idx       (wr_idx_ff),
         .wr_time      (wr_time_ff),
         .in_valid     (hop_valid[k]),
         .in_found     (hop_found[k]),
         .in_time      (hop_time[k]),
         .in_idx       (hop_idx[k]),
         .out_valid    (hop_valid[k+1]),
         .out_found    (hop_found[k+1]),
         .out_time     (hop_time[k+1]),
         .out_idx      (hop_idx[k+1])
      );
   end

   assign sum_in = {1'b0, hop_time[MAX_THREADS]} + (TIME_BITS + 1)'(dur_ff);
   assign next_time_in = sum_in[TIME_BITS] ? '1 : sum_in[TIME_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_count_ff <= COUNT_RESET;
         busy_ff      <= 1'b0;
         launch_ff    <= 1'b0;
         strobe_ff    <= 1'b0;
         wr_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            csr_count_ff <= csr_write_data;
         end
         launch_ff   <= accept;
         strobe_ff   <= done;
         wr_valid_ff <= done;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (done) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dur_ff <= req_job_duration;
      end
      if (done) begin
         rsp_index_ff <= INDEX_W'(hop_idx[MAX_THREADS]);
         rsp_start_ff <= START_W'(hop_time[MAX_THREADS]);
         wr_idx_ff    <= hop_idx[MAX_THREADS];
         wr_time_ff   <= next_time_in;
      end
   end

   assign busy             = busy_ff;
   assign strobe           = strobe_ff;
   assign rsp_thread_index = rsp_index_ff;
   assign rsp_start_time   = rsp_start_ff;

endmodule

// ----- hw/rtl/eftd_checker.sv -----
// Port-level checker for the earliest free thread dispatcher, with the bind
// that attaches it to the top level. Depends on eftd_pkg.
module eftd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic [eftd_pkg::DURATION_W-1:0] req_job_duration,
   input logic                            strobe,
   input logic [eftd_pkg::INDEX_W-1:0]    rsp_thread_index,
   input logic [eftd_pkg::START_W-1:0]    rsp_start_time,
   input logic                            csr_write_enable,
   input logic [eftd_pkg::COUNT_W-1:0]    csr_write_data
);

   // Every accepted transaction makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after an accepted transaction");

   // A result is shown for exactly one cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      strobe |=> !strobe)
      else $error("strobe held for more than one cycle");

   // A result only ends a busy period.
   a_strobe_ends_busy: assert property (@(posedge clock) disable iff (reset)
      strobe |-> !busy && $past(busy))
      else $error("strobe without a transaction in flight");

   // The block never goes idle without delivering the result.
   a_busy_fall_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> strobe)
      else $error("busy dropped without a result");

endmodule

bind earliest_free_thread_dispatcher eftd_checker u_eftd_checker (.*);

// ----- test/dispatch_checker.sv -----
`timescale 1ns / 100ps
// Checker for the earliest free thread dispatcher: watches the job, result and
// thread count ports, predicts each dispatch and compares it with the result.
// Depends on eftd_pkg.
module dispatch_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic [eftd_pkg::DURATION_W-1:0] req_job_duration,
   input  logic                            strobe,
   input  logic [eftd_pkg::INDEX_W-1:0]    rsp_thread_index,
   input  logic [eftd_pkg::START_W-1:0]    rsp_start_time,
   input  logic                            csr_write_enable,
   input  logic [eftd_pkg::COUNT_W-1:0]    csr_write_data,
   output int                              pending,
   output int                              failures
);
   import eftd_pkg::*;

   localparam int THREADS = DEF_MAX_THREADS;
   localparam int TIME_W  = DEF_TIME_BITS;

   typedef struct packed {
      logic [INDEX_W-1:0] thread_index;
      logic [START_W-1:0] start_time;
   } dispatch_type;

   logic [TIME_W-1:0]  free_at [THREADS];
   logic [COUNT_W-1:0] thread_count;
   dispatch_type       expected_dispatches [$];
   int                 mismatch_count = 0;

   function automatic dispatch_type dispatch_job(input logic [DURATION_W-1:0] duration);
      int              active;
      int              winner;
      logic [TIME_W:0] sum;
      dispatch_type    result;
      active = (thread_count == 0) ? 1 : (thread_count > THREADS) ? THREADS : thread_count;
      winner = 0;
      for (int t = 1; t < active; t++)
         if (free_at[t] < free_at[winner]) winner = t;
      sum = {1'b0, free_at[winner]} + (TIME_W + 1)'(duration);
      result.thread_index = winner[INDEX_W-1:0];
      result.start_time   = START_W'(free_at[winner]);
      free_at[winner]     = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
      return result;
   endfunction

   always @(posedge clock) begin
      dispatch_type want;
      if (reset) begin
         foreach (free_at[t]) free_at[t] = '0;
         thread_count = COUNT_RESET;
         expected_dispatches.delete();
      end else begin
         if (strobe) begin
            if (expected_dispatches.size() == 0) begin
               $display("%0t: unexpected result, expected none, got thread %0d start %0d",
                        $time, rsp_thread_index, rsp_start_time);
               mismatch_count++;
            end else begin
               want = expected_dispatches.pop_front();
               if (rsp_thread_index !== want.thread_index) begin
                  $display("%0t: thread_index expected %0d, actual %0d",
                           $time, want.thread_index, rsp_thread_index);
                  mismatch_count++;
               end
               if (rsp_start_time !== want.start_time) begin
                  $display("%0t: start_time expected %0d, actual %0d",
                           $time, want.start_time, rsp_start_time);
                  mismatch_count++;
               end
            end
         end
         if (csr_write_enable) thread_count = csr_write_data;
         if (start && !busy) begin
            expected_dispatches.insert(expected_dispatches.size(),
                                       dispatch_job(req_job_duration));
         end
      end
      pending  <= expected_dispatches.size();
      failures <= mismatch_count;
   end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the earliest free thread dispatcher: makes the job and
// thread count stimulus and gives the verdict. Depends on eftd_pkg,
// dispatch_checker and earliest_free_thread_dispatcher.
module tb;
   import eftd_pkg::*;

   localparam int RANDOM_JOBS    = 650;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = DEF_MAX_THREADS + 8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic [DURATION_W-1:0] req_job_duration = '0;
   logic                  csr_write_enable = 1'b0;
   logic [COUNT_W-1:0]    csr_write_data = '0;
   logic                  busy;
   logic                  strobe;
   logic [INDEX_W-1:0]    rsp_thread_index;
   logic [START_W-1:0]    rsp_start_time;
   int                    pending;
   int                    failures;
   int                    idle_cycles = 0;
   int                    jobs_sent = 0;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   earliest_free_thread_dispatcher dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_job_duration (req_job_duration),
      .strobe           (strobe),
      .rsp_thread_index (rsp_thread_index),
      .rsp_start_time   (rsp_start_time),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   dispatch_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_job_duration (req_job_duration),
      .strobe           (strobe),
      .rsp_thread_index (rsp_thread_index),
      .rsp_start_time   (rsp_start_time),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .pending          (pending),
      .failures         (failures)
   );

   // Called at a clock edge; returns at the edge that accepts the transaction.
   task automatic send_job(input logic [DURATION_W-1:0] duration, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_job_duration <= duration;
      do @(posedge clock); while (busy);
      jobs_sent++;
   endtask

   task automatic write_thread_count(input logic [COUNT_W-1:0] count);
      do @(posedge clock); while (pending != 0 || busy);
      csr_write_enable <= 1'b1;
      csr_write_data <= count;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [DURATION_W-1:0] pick_duration();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return $urandom_range(0, 15);
         4:       return $urandom_range(0, 1000);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [COUNT_W-1:0] pick_count();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return COUNT_W'($urandom_range(DEF_MAX_THREADS + 1, 31));
         2:       return COUNT_W'(DEF_MAX_THREADS);
         3:       return COUNT_W'(1);
         default: return COUNT_W'($urandom_range(1, DEF_MAX_THREADS));
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset || (start && !busy) || strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int  phase_jobs;
      bit  no_gaps;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // All threads start free at zero, so ties go to the lowest index.
      send_job(32'hFFFF_FFFF, 0);
      send_job(32'h0000_0000, 0);
      send_job(32'h0000_0001, 2);
      send_job(32'h8000_0000, 0);
      start <= 1'b0;

      // A count of zero behaves as one thread.
      write_thread_count(5'd0);
      send_job(32'h5555_5555, 1);
      send_job(32'hAAAA_AAAA, 0);
      start <= 1'b0;

      // A count above the built maximum uses every thread.
      write_thread_count(5'd31);
      repeat (14) send_job(32'h0000_0007, 0);
      start <= 1'b0;

      write_thread_count(5'd2);
      repeat (3) send_job(32'h0000_0003, 1);
      start <= 1'b0;

      write_thread_count(5'd16);
      send_job(32'h0000_0000, 0);
      start <= 1'b0;

      while (jobs_sent < RANDOM_JOBS) begin
         write_thread_count(pick_count());
         phase_jobs = $urandom_range(15, 60);
         no_gaps = ($urandom_range(0, 3) == 0);
         repeat (phase_jobs)
            send_job(pick_duration(), no_gaps ? 0 : $urandom_range(0, 6));
         start <= 1'b0;
      end

      write_thread_count(5'd16);
      repeat (20) send_job(pick_duration(), $urandom_range(0, 6));
      start <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- earliest_free_thread_dispatcher.f -----
hw/rtl/eftd_pkg.sv
hw/rtl/eftd_cell.sv
hw/rtl/earliest_free_thread_dispatcher.sv
hw/rtl/eftd_checker.sv
test/dispatch_checker.sv
test/tb.sv
